// File: hdl/mpq_pkg.sv
// shared constants, codes and control types for the unsorted max priority queue
package mpq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OP_W     = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_TOP  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LAST,
    S_MOVE,
    S_RESULT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic scan;
    logic read_last;
    logic move;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_scan_op;
    logic is_pop;
    logic empty;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/mpq_ctrl.sv
// sequencing state machine for push, scan, move and result hand-off
module mpq_ctrl
  import mpq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (stat_i.is_scan_op && !stat_i.empty) state_d = S_SCAN;
        else state_d = S_RESULT;
      end
      S_SCAN: begin
        if (stat_i.scan_done) state_d = stat_i.is_pop ? S_LAST : S_RESULT;
      end
      S_LAST:   state_d = S_MOVE;
      S_MOVE:   state_d = S_RESULT;
      S_RESULT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_DECODE: cmd_o.decode    = 1'b1;
      S_SCAN:   cmd_o.scan      = 1'b1;
      S_LAST:   cmd_o.read_last = 1'b1;
      S_MOVE:   cmd_o.move      = 1'b1;
      S_RESULT: cmd_o.emit      = stat_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

// File: hdl/mpq_dpath.sv
// entry store, fill count, max scan comparator and output register
module mpq_dpath
  import mpq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output stat_t                      stat_o,
  input  logic        [OP_W-1:0]     opcode_i,
  input  logic signed [DATA_W-1:0]   value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DATA_W-1:0]   max_value_o,
  output logic        [COUNT_W-1:0]  count_o,
  output logic                       is_empty_o,
  output logic        [STATUS_W-1:0] status_o
);

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [DATA_W-1:0] best_q, best_d;
  logic [ADDR_W-1:0] best_idx_q, best_idx_d;
  status_e           status_q, status_d;
  logic              out_valid_q;

  logic              is_push, is_scan_op, full, empty;
  logic              we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data;
  logic [CNT_W-1:0]  last_idx;
  logic [CNT_W-1:0]  prev_idx;

  assign is_push    = (op_q == OP_PUSH);
  assign is_scan_op = (op_q == OP_POP) || (op_q == OP_TOP);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign last_idx   = count_q - CNT_W'(1);
  assign prev_idx   = idx_q - CNT_W'(1);

  assign stat_o.is_scan_op = is_scan_op;
  assign stat_o.is_pop     = (op_q == OP_POP);
  assign stat_o.empty      = empty;
  assign stat_o.scan_done  = (idx_q == count_q);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  // store write and read port selection
  always_comb begin
    we      = 1'b0;
    wr_addr = count_q[ADDR_W-1:0];
    wr_data = val_q;
    if (cmd_i.decode && is_push && !full) begin
      we = 1'b1;
    end else if (cmd_i.move) begin
      we      = 1'b1;
      wr_addr = best_idx_q;
      wr_data = rd_data_q;
    end
  end

  always_comb begin
    if (cmd_i.read_last) rd_addr = last_idx[ADDR_W-1:0];
    else if (cmd_i.decode) rd_addr = '0;
    else rd_addr = idx_q[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wr_data;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_q <= value_i;
    end
  end

  // control-side registers
  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    status_d   = status_q;
    if (cmd_i.decode) begin
      status_d = ST_OK;
      idx_d    = CNT_W'(1);
      if (is_push) begin
        if (full) status_d = ST_OVER;
        else count_d = count_q + CNT_W'(1);
      end else if (is_scan_op && empty) begin
        status_d = ST_UNDER;
      end
    end
    if (cmd_i.scan) begin
      // data now at the read port belongs to entry idx_q - 1
      if (idx_q == CNT_W'(1) || $signed(rd_data_q) > $signed(best_q)) begin
        best_d     = rd_data_q;
        best_idx_d = prev_idx[ADDR_W-1:0];
      end
      if (idx_q != count_q) idx_d = idx_q + CNT_W'(1);
    end
    if (cmd_i.move) begin
      count_d = last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OP_PUSH;
      count_q    <= '0;
      idx_q      <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
      status_q   <= ST_OK;
    end else begin
      if (cmd_i.capture) op_q <= opcode_i;
      count_q    <= count_d;
      idx_q      <= idx_d;
      best_q     <= best_d;
      best_idx_q <= best_idx_d;
      status_q   <= status_d;
    end
  end

  // output register, refilled as soon as the previous item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      max_value_o <= (is_scan_op && status_q == ST_OK) ? $signed(best_q) : '0;
      count_o     <= COUNT_W'(count_q);
      is_empty_o  <= empty;
      status_o    <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/max_priority_queue_unsorted.sv
// top level of the unsorted max priority queue
// Holds up to 16 signed 32-bit entries in arrival order in a single-port-write
// store with a registered read port. A push, a pop or top on an empty queue, a
// push into a full queue, or opcode 3 goes from decode straight to the result
// state, which loads the output register; the next item can be accepted once
// the result state has handed off. Top walks every held entry through one
// comparator, one entry per cycle; pop then reads the last entry and writes it
// into the vacated slot before the result is loaded. Ties go to the lowest index.
// The result sits in an output register, so the next item is accepted while the
// previous result still waits; one item is worked on at a time, and an item whose
// result finds the output register still held by out_stall_i waits for as long
// as that stall lasts. No clearing pass is needed after reset.
module max_priority_queue_unsorted
  import mpq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic        [OP_W-1:0]     opcode_i,
  input  logic signed [DATA_W-1:0]   value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DATA_W-1:0]   max_value_o,
  output logic        [COUNT_W-1:0]  count_o,
  output logic                       is_empty_o,
  output logic        [STATUS_W-1:0] status_o
);

  cmd_t  cmd;
  stat_t stat;

  mpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mpq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .max_value_o (max_value_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o),
    .status_o    (status_o)
  );

endmodule

// File: tb/sv/mpq_checker.sv
// watches both channels of the unsorted max priority queue, predicts each reply and compares
module mpq_checker
  import mpq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic        [OP_W-1:0]     opcode_i,
  input  logic signed [DATA_W-1:0]   value_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [DATA_W-1:0]   max_value_i,
  input  logic        [COUNT_W-1:0]  count_i,
  input  logic                       is_empty_i,
  input  logic        [STATUS_W-1:0] status_i,
  output int                         pending_o,
  output int                         mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DATA_W-1:0]  max_value;
    logic        [COUNT_W-1:0] count;
    logic                      is_empty;
    status_e                   status;
  } queue_reply_t;

  logic signed [DATA_W-1:0] held [CAPACITY];
  int unsigned              held_n;
  queue_reply_t             pending_replies [$];
  int                       mismatches;

  assign mismatches_o = mismatches;

  initial mismatches = 0;

  task automatic log_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // mirror of the queue: same store order, same tie rule
  task automatic apply_queue_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                                output queue_reply_t reply);
    int unsigned best;
    reply.max_value = '0;
    reply.status    = ST_OK;
    case (op)
      OP_PUSH: begin
        if (held_n >= CAPACITY) begin
          reply.status = ST_OVER;
        end else begin
          held[held_n] = val;
          held_n++;
        end
      end
      OP_POP, OP_TOP: begin
        if (held_n == 0) begin
          reply.status = ST_UNDER;
        end else begin
          best = 0;
          for (int unsigned i = 1; i < held_n; i++) begin
            if (held[i] > held[best]) best = i;
          end
          reply.max_value = held[best];
          if (op == OP_POP) begin
            held[best] = held[held_n - 1];
            held_n--;
          end
        end
      end
      default: ;
    endcase
    reply.count    = held_n[COUNT_W-1:0];
    reply.is_empty = (held_n == 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_reply_t want, fresh;
    if (!rst_ni) begin
      held_n = 0;
      pending_replies.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_replies.size() == 0) begin
          log_mismatch("reply with no item pending", max_value_i, 0);
        end else begin
          want = pending_replies.pop_front();
          if (max_value_i !== want.max_value)
            log_mismatch("max_value", max_value_i, want.max_value);
          if (count_i !== want.count) log_mismatch("count", count_i, want.count);
          if (is_empty_i !== want.is_empty) log_mismatch("is_empty", is_empty_i, want.is_empty);
          if (status_i !== want.status) log_mismatch("status", status_i, want.status);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_queue_op(opcode_i, value_i, fresh);
        pending_replies.insert(pending_replies.size(), fresh);
      end
      pending_o <= pending_replies.size();
    end
  end

endmodule

// File: tb/sv/max_priority_queue_unsorted_test.sv
// stimulus and verdict for the unsorted max priority queue
module max_priority_queue_unsorted_test;
  import mpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid;
  logic                       in_stall;
  logic        [OP_W-1:0]     opcode;
  logic signed [DATA_W-1:0]   value;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DATA_W-1:0]   max_value;
  logic        [COUNT_W-1:0]  count;
  logic                       is_empty;
  logic        [STATUS_W-1:0] status;
  int                         pending;
  int                         mismatch_total;
  int                         hold_asks = 0;
  int                         holds_done = 0;

  max_priority_queue_unsorted uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .opcode_i    (opcode),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .max_value_o (max_value),
    .count_o     (count),
    .is_empty_o  (is_empty),
    .status_o    (status)
  );

  mpq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .opcode_i     (opcode),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .max_value_i  (max_value),
    .count_i      (count),
    .is_empty_i   (is_empty),
    .status_i     (status),
    .pending_o    (pending),
    .mismatches_o (mismatch_total)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("max_priority_queue_unsorted regression: fail");
    $finish;
  end

  // mix of extremes, a narrow band for ties, and full-range values
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return $signed($urandom_range(0, 8)) - 4;
      3, 4, 5: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin : receiver
    rx_mode_e mode;
    int       left;
    mode = RX_FREE;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ((left % 5) < 2);
        endcase
      end
    end
  end

  initial begin : sender
    int                n;
    int                burst;
    int                gap;
    int                push_bias;
    int                r;
    logic [OP_W-1:0]   op;
    in_valid <= 1'b0;
    opcode   <= OP_PUSH;
    value    <= '0;
    rst_ni   <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, then extremes with a tie on the maximum
    send_item(OP_POP, pick_value());
    send_item(OP_TOP, pick_value());
    send_item(OP_NONE, $urandom);
    send_item(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
    send_item(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
    send_item(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, '1);
    send_item(OP_TOP, pick_value());
    send_item(OP_POP, pick_value());
    send_item(OP_POP, pick_value());
    // fill up and push once more into a full store
    repeat (CAPACITY - 3) send_item(OP_PUSH, pick_value());
    send_item(OP_PUSH, pick_value());
    send_item(OP_TOP, pick_value());
    in_valid <= 1'b0;
    @(posedge clk_i);

    n = 0;
    push_bias = 50;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n < RANDOM_ITEMS) begin
        if (n % 150 == 0) push_bias = $urandom_range(10, 90);
        if (n == 300 || n == 1000) hold_asks <= hold_asks + 1;
        if (n == 650 || n == 1300) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        r = $urandom_range(0, 99);
        if (r < 3) op = OP_NONE;
        else if (r < 3 + push_bias) op = OP_PUSH;
        else if ($urandom_range(0, 1) == 0) op = OP_POP;
        else op = OP_TOP;
        send_item(op, pick_value());
        n++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("max_priority_queue_unsorted regression: pass");
    end else begin
      $display("max_priority_queue_unsorted regression: fail");
    end
    $finish;
  end

endmodule
